### rtl/rhc_pkg.sv
// Package for the RGB to HSV converter: widths, channel payload structs and
// the record that travels down the divider cell chain. No dependencies.
`timescale 1ns / 1ps

package rhc_pkg;

	// Component code width and fraction width of hue and saturation
	localparam int COMP_BITS = 8;
	localparam int FRAC_BITS = 16;
	// Hue numerator and divisor hold up to six times the component span
	localparam int HUE_BITS  = COMP_BITS + 3;

	typedef struct packed {
		logic [COMP_BITS-1:0] red;
		logic [COMP_BITS-1:0] green;
		logic [COMP_BITS-1:0] blue;
		logic [COMP_BITS-1:0] alpha_in;
	} pixel_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] hue;
		logic [FRAC_BITS-1:0] saturation;
		logic [COMP_BITS-1:0] value;
		logic [COMP_BITS-1:0] alpha_out;
	} hsv_t;

	// Partial state of both divisions plus the pass-through fields
	typedef struct packed {
		logic [COMP_BITS-1:0] sat_rem;
		logic [COMP_BITS-1:0] sat_div;
		logic [FRAC_BITS-1:0] sat_low;
		logic [FRAC_BITS-1:0] sat_quo;
		logic [HUE_BITS-1:0]  hue_rem;
		logic [HUE_BITS-1:0]  hue_div;
		logic [FRAC_BITS-1:0] hue_quo;
		logic                 grey;
		logic [COMP_BITS-1:0] value;
		logic [COMP_BITS-1:0] alpha;
	} div_stage_t;

endpackage

### rtl/rgb_to_hsv_convert_core.sv
// Pipeline: one front stage, one divider cell per fraction bit, one output register.
// Throughput: one pixel per cycle while hsv_stall is low; each stage holds
// only while the stage after it is full and stalled, so bubbles are squeezed out.
// Reset clears all valid flags asynchronously; payload registers are not reset.
// Top level of the converter; uses rhc_pkg, rhc_prep and rhc_div_cell.
`timescale 1ns / 1ps

module rgb_to_hsv_convert_core import rhc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pixel_valid,
	output logic   pixel_stall,
	input  pixel_t pixel,
	output logic   hsv_valid,
	input  logic   hsv_stall,
	output hsv_t   hsv
);

	logic       vld [0:FRAC_BITS];
	div_stage_t stg [0:FRAC_BITS];
	logic       ld  [0:FRAC_BITS];
	logic       prep_load;
	logic       res_valid_q;
	hsv_t       res_q, res_nxt;

	// Output register loads when empty or drained
	assign ld[FRAC_BITS] = !res_valid_q || !hsv_stall;

	rhc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (prep_load),
		.pix_valid (pixel_valid),
		.pix       (pixel),
		.valid_s1  (vld[0]),
		.stage_s1  (stg[0])
	);

	assign prep_load   = !vld[0] || ld[0];
	assign pixel_stall = !prep_load;

	// Divider chain, one quotient bit per cell
	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
		assign ld[k] = !vld[k+1] || ld[k+1];

		rhc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (ld[k]),
			.in_valid (vld[k]),
			.in_stage (stg[k]),
			.valid_q  (vld[k+1]),
			.stage_q  (stg[k+1])
		);
	end

	// Drop hue and saturation for grey and black pixels
	always_comb begin
		res_nxt.hue        = stg[FRAC_BITS].grey ? '0 : stg[FRAC_BITS].hue_quo;
		res_nxt.saturation = stg[FRAC_BITS].grey ? '0 : stg[FRAC_BITS].sat_quo;
		res_nxt.value      = stg[FRAC_BITS].value;
		res_nxt.alpha_out  = stg[FRAC_BITS].alpha;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld[FRAC_BITS]) begin
			res_valid_q <= vld[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[FRAC_BITS]) begin
			res_q <= res_nxt;
		end
	end

	assign hsv_valid = res_valid_q;
	assign hsv       = res_q;

	// A black pixel carries no hue and no saturation
	a_black_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.value == '0) |->
		(res_q.hue == '0 && res_q.saturation == '0))
		else $error("black pixel with nonzero hue or saturation");

	// Zero saturation only for grey pixels, which have zero hue
	a_sat_hue : assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.saturation == '0) |-> (res_q.hue == '0))
		else $error("zero saturation with nonzero hue");

	// An accepted transaction lands in the front stage
	a_accept : assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) |=> vld[0])
		else $error("accepted transaction lost at front stage");

	// A front stage item moves into the first cell when the chain advances
	a_advance : assert property (@(posedge clk) disable iff (!arst_n)
		(vld[0] && ld[0]) |=> vld[1])
		else $error("front stage item lost entering divider chain");

endmodule

### rtl/rhc_prep.sv
// Front stage of the converter: max/min, sector numerator and divisors.
// Depends on rhc_pkg; feeds the first divider cell.
`timescale 1ns / 1ps

module rhc_prep import rhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       pix_valid,
	input  pixel_t     pix,
	output logic       valid_s1,
	output div_stage_t stage_s1
);

	logic [COMP_BITS-1:0]           r, g, b, vmax, vmin, d;
	logic [HUE_BITS-1:0]            d_x, two_d, four_d, six_d, num, num_fix;
	logic [COMP_BITS+FRAC_BITS-1:0] sat_num;
	div_stage_t                     nxt;

	assign r = pix.red;
	assign g = pix.green;
	assign b = pix.blue;

	// Pick largest (red wins ties, then green) and smallest
	always_comb begin
		if (r >= g && r >= b) begin
			vmax = r;
		end else if (g >= b) begin
			vmax = g;
		end else begin
			vmax = b;
		end
		if (r <= g && r <= b) begin
			vmin = r;
		end else if (g <= b) begin
			vmin = g;
		end else begin
			vmin = b;
		end
	end

	assign d      = vmax - vmin;
	assign d_x    = {3'b000, d};
	assign two_d  = d_x << 1;
	assign four_d = d_x << 2;
	assign six_d  = four_d + two_d;

	// Sector position scaled by the span
	always_comb begin
		if (r == vmax) begin
			if (g == vmin) begin
				num = six_d - {3'b000, b - vmin};
			end else begin
				num = {3'b000, g - vmin};
			end
		end else if (g == vmax) begin
			if (b == vmin) begin
				num = two_d - {3'b000, r - vmin};
			end else begin
				num = two_d + {3'b000, b - vmin};
			end
		end else begin
			if (r == vmin) begin
				num = four_d - {3'b000, g - vmin};
			end else begin
				num = four_d + {3'b000, r - vmin};
			end
		end
	end

	// Wrap a full turn to zero so the quotient fits the fraction width
	assign num_fix = (num == six_d) ? '0 : num;

	// d * (2^FRAC_BITS - 1) as a shift and subtract
	assign sat_num = {d, {FRAC_BITS{1'b0}}} - {{FRAC_BITS{1'b0}}, d};

	always_comb begin
		nxt.sat_rem = sat_num[COMP_BITS+FRAC_BITS-1:FRAC_BITS];
		nxt.sat_low = sat_num[FRAC_BITS-1:0];
		nxt.sat_div = vmax;
		nxt.sat_quo = '0;
		nxt.hue_rem = num_fix;
		nxt.hue_div = six_d;
		nxt.hue_quo = '0;
		nxt.grey    = (d == '0);
		nxt.value   = vmax;
		nxt.alpha   = pix.alpha_in;
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= pix_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			stage_s1 <= nxt;
		end
	end

endmodule

### rtl/rhc_div_cell.sv
// One cell of the divider chain: one restoring step of the saturation and
// the hue division, result registered. Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_div_cell import rhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       in_valid,
	input  div_stage_t in_stage,
	output logic       valid_q,
	output div_stage_t stage_q
);

	logic [COMP_BITS:0] sat_trial;
	logic [HUE_BITS:0]  hue_trial;
	logic               sat_bit, hue_bit;
	div_stage_t         nxt;

	// Shift in the next dividend bit and trial-subtract
	assign sat_trial = {in_stage.sat_rem, in_stage.sat_low[FRAC_BITS-1]};
	assign hue_trial = {in_stage.hue_rem, 1'b0};
	assign sat_bit   = (sat_trial >= {1'b0, in_stage.sat_div});
	assign hue_bit   = (hue_trial >= {1'b0, in_stage.hue_div});

	always_comb begin
		nxt         = in_stage;
		nxt.sat_low = {in_stage.sat_low[FRAC_BITS-2:0], 1'b0};
		nxt.sat_quo = {in_stage.sat_quo[FRAC_BITS-2:0], sat_bit};
		nxt.hue_quo = {in_stage.hue_quo[FRAC_BITS-2:0], hue_bit};
		if (sat_bit) begin
			nxt.sat_rem = COMP_BITS'(sat_trial - {1'b0, in_stage.sat_div});
		end else begin
			nxt.sat_rem = sat_trial[COMP_BITS-1:0];
		end
		if (hue_bit) begin
			nxt.hue_rem = HUE_BITS'(hue_trial - {1'b0, in_stage.hue_div});
		end else begin
			nxt.hue_rem = hue_trial[HUE_BITS-1:0];
		end
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (load) begin
			stage_q <= nxt;
		end
	end

endmodule

### verif/tb_rgb_to_hsv_convert_core.sv
// Self-checking testbench for rgb_to_hsv_convert_core: drives pixels, predicts
// hue, saturation, value and alpha, and checks every output transaction in order.
// Depends on rhc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_convert_core;
	import rhc_pkg::*;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   pixel_valid;
	logic   pixel_stall;
	pixel_t pixel;
	logic   hsv_valid;
	logic   hsv_stall = 1'b0;
	hsv_t   hsv;

	// Pending HSV results in arrival order, and the error tally
	hsv_t expected_hsv[$];
	int   error_count = 0;
	// Chance in percent of an idle cycle on each side
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;

	rgb_to_hsv_convert_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hsv        (hsv)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Compute hue, saturation and value of one pixel in exact integer math
	function automatic hsv_t predict_hsv(input pixel_t p);
		logic [63:0] r, g, b, vmax, vmin, span, pos, q;
		hsv_t        h;
		r = 64'(p.red);
		g = 64'(p.green);
		b = 64'(p.blue);
		vmax = (r > g) ? r : g;
		vmax = (vmax > b) ? vmax : b;
		vmin = (r < g) ? r : g;
		vmin = (vmin < b) ? vmin : b;
		span = vmax - vmin;
		h.hue = '0;
		h.saturation = '0;
		if (vmax != 0 && span != 0) begin
			q = (span * ((64'd1 << FRAC_BITS) - 64'd1)) / vmax;
			h.saturation = q[FRAC_BITS-1:0];
			// Pick the sector base from the largest component, direction from the smallest
			if (r == vmax) begin
				if (g == vmin)
					pos = 64'd6 * span - (b - vmin);
				else
					pos = g - vmin;
			end else if (g == vmax) begin
				if (b == vmin)
					pos = 64'd2 * span - (r - vmin);
				else
					pos = 64'd2 * span + (b - vmin);
			end else begin
				if (r == vmin)
					pos = 64'd4 * span - (g - vmin);
				else
					pos = 64'd4 * span + (r - vmin);
			end
			// Truncation to the field width wraps a full turn to zero
			q = (pos << FRAC_BITS) / (64'd6 * span);
			h.hue = q[FRAC_BITS-1:0];
		end
		h.value = vmax[COMP_BITS-1:0];
		h.alpha_out = p.alpha_in;
		return h;
	endfunction

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			error_count++;
		end
	endtask

	// Record accepted pixels and check each accepted result against the oldest one
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall)
				expected_hsv.push_back(predict_hsv(pixel));
			if (hsv_valid && !hsv_stall) begin
				if (expected_hsv.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, hsv);
					error_count++;
				end else begin
					hsv_t want;
					want = expected_hsv.pop_front();
					report_field("hue", 32'(want.hue), 32'(hsv.hue));
					report_field("saturation", 32'(want.saturation),
						32'(hsv.saturation));
					report_field("value", 32'(want.value), 32'(hsv.value));
					report_field("alpha_out", 32'(want.alpha_out), 32'(hsv.alpha_out));
				end
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk)
		hsv_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// Send one pixel; return at the edge where the transaction is taken
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.alpha_in = a;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
	endtask

	// Black, grey, white, full turn and the tie-breaking cases
	task automatic test_special_pixels();
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128, 8'd77);
		send_pixel(8'd1, 8'd1, 8'd1, 8'd170);
		send_pixel(8'd200, 8'd50, 8'd50, 8'd85);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd0, 8'd15);
		send_pixel(8'd0, 8'd255, 8'd255, 8'd240);
		send_pixel(8'd255, 8'd0, 8'd255, 8'd90);
		send_pixel(8'd1, 8'd1, 8'd0, 8'd165);
	endtask

	// Both halves of each sector and a one-code span
	task automatic test_sector_pixels();
		send_pixel(8'd255, 8'd128, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd128, 8'd2);
		send_pixel(8'd100, 8'd255, 8'd0, 8'd4);
		send_pixel(8'd0, 8'd255, 8'd100, 8'd8);
		send_pixel(8'd0, 8'd100, 8'd255, 8'd16);
		send_pixel(8'd100, 8'd0, 8'd255, 8'd32);
		send_pixel(8'd255, 8'd254, 8'd254, 8'd64);
		send_pixel(8'd254, 8'd255, 8'd253, 8'd128);
		send_pixel(8'd0, 8'd1, 8'd0, 8'd254);
		send_pixel(8'd0, 8'd0, 8'd1, 8'd127);
	endtask

	// Random pixels, weighted toward greys, ties and tiny spans
	task automatic test_random_pixels(input int count, input int send_pct,
			input int recv_pct);
		logic [7:0] r, g, b, a;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			a = 8'($urandom);
			case ($urandom_range(0, 9))
				0: begin
					g = r;
					b = r;
				end
				1: g = r;
				2: b = g;
				3: b = r;
				4: begin
					r = 8'($urandom_range(0, 3));
					g = 8'($urandom_range(0, 3));
					b = 8'($urandom_range(0, 3));
				end
				default: ;
			endcase
			send_pixel(r, g, b, a);
		end
	endtask

	// Reset, run the tests in turn, drain and report
	initial begin
		arst_n <= 1'b0;
		pixel_valid <= 1'b0;
		pixel <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_pixels();
		test_sector_pixels();
		test_random_pixels(650, 17, 51);
		test_random_pixels(650, 51, 17);
		test_random_pixels(650, 0, 0);
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (expected_hsv.size() != 0)
			@(posedge clk);
		// Allow the pipeline depth for any stray result
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
